// ===== rtl/gha_pkg.sv =====
// Shared constants, types and codes of the generational handle allocator.
`default_nettype none
package gha_pkg;

	localparam int CAPACITY   = 1024;
	localparam int GEN_BITS   = 16;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int LINK_W     = $clog2(CAPACITY + 1);
	localparam int SIZE_RESET = (1024 > CAPACITY) ? CAPACITY : 1024;

	// fixed field widths of the channels
	localparam int CMD_W   = 2;
	localparam int PAY_W   = 64;
	localparam int STRAT_W = 8;
	localparam int HIDX_W  = 10;
	localparam int HGEN_W  = 16;
	localparam int CNT_W   = 11;
	localparam int CFG_W   = 11;
	localparam int ST_W    = 3;

	localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(CAPACITY);

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_LOOKUP  = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_GROW    = 2'd3
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK         = 3'd0,
		ST_FULL       = 3'd1,
		ST_ZERO_STRAT = 3'd2,
		ST_RANGE      = 3'd3,
		ST_STALE      = 3'd4,
		ST_BAD_GROW   = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_EXEC  = 4'b0100,
		S_GROW  = 4'b1000
	} state_t;

	// one slot's control word
	typedef struct packed {
		logic [GEN_BITS-1:0] gen;
		logic                alloc;
		logic [LINK_W-1:0]   link;
	} meta_t;

	localparam int META_W = $bits(meta_t);

	// start of a slot walk: [first, stop) is written, links chain up to chain_end
	typedef struct packed {
		logic                start;
		logic [LINK_W-1:0]   first;
		logic [LINK_W-1:0]   stop;
		logic [LINK_W-1:0]   chain_end;
		logic [LINK_W-1:0]   tail;
		logic [GEN_BITS-1:0] gen;
	} walk_cmd_t;

	typedef struct packed {
		logic             busy;
		logic [IDX_W-1:0] addr;
		meta_t            data;
	} walk_st_t;

endpackage
`default_nettype wire

// ===== rtl/gha_ifs.sv =====
// Channel interfaces: request, response and configuration write.
`default_nettype none
interface gha_req_if;
	logic                         valid;
	logic                         ready;
	logic [gha_pkg::CMD_W-1:0]    cmd;
	logic [gha_pkg::PAY_W-1:0]    payload;
	logic [gha_pkg::STRAT_W-1:0]  strategy_id;
	logic [gha_pkg::HIDX_W-1:0]   handle_index;
	logic [gha_pkg::HGEN_W-1:0]   handle_generation;
	logic [gha_pkg::CNT_W-1:0]    grow_count;

	modport source (output valid, cmd, payload, strategy_id, handle_index,
		handle_generation, grow_count, input ready);
	modport sink (input valid, cmd, payload, strategy_id, handle_index,
		handle_generation, grow_count, output ready);
endinterface

interface gha_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [gha_pkg::ST_W-1:0]    status;
	logic [gha_pkg::HIDX_W-1:0]  out_index;
	logic [gha_pkg::HGEN_W-1:0]  out_generation;
	logic [gha_pkg::PAY_W-1:0]   out_payload;

	modport source (output valid, status, out_index, out_generation, out_payload,
		input ready);
	modport sink (input valid, status, out_index, out_generation, out_payload,
		output ready);
endinterface

interface gha_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [gha_pkg::CFG_W-1:0]  data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/gha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gha_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/gha_walk.sv =====
// Slot walker: writes a run of control words one slot per cycle (clear and grow).
`default_nettype none
module gha_walk (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire gha_pkg::walk_cmd_t cmd,
	output gha_pkg::walk_st_t       st
);

	logic                         busy_q;
	logic [gha_pkg::LINK_W-1:0]   idx_q;
	logic [gha_pkg::LINK_W-1:0]   stop_q;
	logic [gha_pkg::LINK_W-1:0]   chain_q;
	logic [gha_pkg::LINK_W-1:0]   tail_q;
	logic [gha_pkg::GEN_BITS-1:0] gen_q;
	logic [gha_pkg::LINK_W-1:0]   nxt;

	assign nxt = idx_q + gha_pkg::LINK_W'(1);

	// reset starts the full clearing pass with the reset size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			idx_q   <= '0;
			stop_q  <= gha_pkg::LINK_W'(gha_pkg::CAPACITY);
			chain_q <= gha_pkg::LINK_W'(gha_pkg::SIZE_RESET);
			tail_q  <= gha_pkg::LINK_NONE;
			gen_q   <= '0;
		end else if (cmd.start) begin
			busy_q  <= 1'b1;
			idx_q   <= cmd.first;
			stop_q  <= cmd.stop;
			chain_q <= cmd.chain_end;
			tail_q  <= cmd.tail;
			gen_q   <= cmd.gen;
		end else if (busy_q) begin
			idx_q <= nxt;
			if (nxt == stop_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		st.busy       = busy_q;
		st.addr       = idx_q[gha_pkg::IDX_W-1:0];
		st.data.gen   = gen_q;
		st.data.alloc = 1'b0;
		st.data.link  = (nxt < chain_q) ? nxt : tail_q;
	end

endmodule
`default_nettype wire

// ===== rtl/generational_handle_allocator.sv =====
// Top level: generation-checked handle table with a LIFO free list.
//
//  channel | dir | handshake         | content
//  --------+-----+-------------------+------------------------------------------
//  cfg     | in  | valid/ready       | table size, rebuilds the table
//  req     | in  | valid/ready       | cmd, payload, strategy_id, handle, grow_count
//  rsp     | out | valid/ready       | status, out_index, out_generation, out_payload
//
// Alloc, lookup and release: the accept edge launches the slot read, and the execute
// edge checks the registered read data and writes the slot back.
// Grow: the execute edge starts the walker, which makes one write per new slot;
// req.ready rises once the sequencer has seen the walker done.
// After reset and after every nonzero size write, a clearing pass writes all
// 1024 slots, one per cycle, and req.ready rises once the sequencer has seen the
// walker done; cfg is always ready.
// A full response register stalls the execute cycle; the next request is still
// taken while the last response waits.
`default_nettype none
module generational_handle_allocator (
	input wire logic clk,
	input wire logic arst_n,
	gha_cfg_if.sink  cfg,
	gha_req_if.sink  req,
	gha_rsp_if.source rsp
);

	gha_pkg::state_t              state_q;
	logic [gha_pkg::LINK_W-1:0]   free_head_q;
	logic [gha_pkg::LINK_W-1:0]   active_q;

	// latched request
	gha_pkg::cmd_t                cmd_q;
	logic [gha_pkg::PAY_W-1:0]    payload_q;
	logic [gha_pkg::STRAT_W-1:0]  strat_q;
	logic [gha_pkg::IDX_W-1:0]    hidx_q;
	logic [gha_pkg::HGEN_W-1:0]   hgen_q;
	logic [gha_pkg::CNT_W-1:0]    count_q;
	logic [gha_pkg::IDX_W-1:0]    addr_q;

	// response register
	logic                         rsp_valid_q;
	gha_pkg::status_t             rsp_status_q;
	logic [gha_pkg::HIDX_W-1:0]   rsp_idx_q;
	logic [gha_pkg::HGEN_W-1:0]   rsp_gen_q;
	logic [gha_pkg::PAY_W-1:0]    rsp_pay_q;

	logic                         cfg_wr;
	logic [gha_pkg::LINK_W-1:0]   cfg_size;
	logic                         req_acc;
	logic                         out_free;
	logic                         exec_fire;

	logic [gha_pkg::IDX_W-1:0]    rd_addr;
	logic [gha_pkg::META_W-1:0]   rd_word;
	gha_pkg::meta_t               rd_meta;
	logic [gha_pkg::PAY_W-1:0]    rd_pay;

	gha_pkg::walk_cmd_t           walk_cmd;
	gha_pkg::walk_st_t            walk;

	// execute-cycle decisions
	gha_pkg::status_t             st_d;
	logic [gha_pkg::HIDX_W-1:0]   idx_d;
	logic [gha_pkg::HGEN_W-1:0]   gen_d;
	logic [gha_pkg::PAY_W-1:0]    pay_d;
	logic                         ex_we;
	gha_pkg::meta_t               ex_meta;
	logic                         pay_we;
	logic                         head_ld;
	logic [gha_pkg::LINK_W-1:0]   head_d;
	logic                         grow_ok;
	logic [gha_pkg::LINK_W-1:0]   grow_end;

	logic                         m_we;
	logic [gha_pkg::IDX_W-1:0]    m_waddr;
	gha_pkg::meta_t               m_wdata;

	assign cfg.ready = 1'b1;
	// a zero size is ignored, anything above capacity saturates
	assign cfg_wr    = cfg.valid && (cfg.data != '0);
	assign cfg_size  = (32'(cfg.data) > 32'(gha_pkg::CAPACITY)) ?
		gha_pkg::LINK_W'(gha_pkg::CAPACITY) : gha_pkg::LINK_W'(cfg.data);

	assign req.ready = (state_q == gha_pkg::S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign exec_fire = (state_q == gha_pkg::S_EXEC) && out_free;

	// launch the slot read on the accept edge; hold the address while stalled
	always_comb begin
		if (state_q == gha_pkg::S_IDLE) begin
			rd_addr = (gha_pkg::cmd_t'(req.cmd) == gha_pkg::CMD_ALLOC) ?
				free_head_q[gha_pkg::IDX_W-1:0] : gha_pkg::IDX_W'(req.handle_index);
		end else begin
			rd_addr = addr_q;
		end
	end

	assign rd_meta = gha_pkg::meta_t'(rd_word);

	// checks and write-back of one request
	always_comb begin
		st_d    = gha_pkg::ST_OK;
		idx_d   = '0;
		gen_d   = '0;
		pay_d   = '0;
		ex_we   = 1'b0;
		ex_meta = rd_meta;
		pay_we  = 1'b0;
		head_ld = 1'b0;
		head_d  = free_head_q;
		grow_ok = 1'b0;
		unique case (cmd_q) inside
			gha_pkg::CMD_ALLOC: begin
				if (strat_q == '0) begin
					st_d = gha_pkg::ST_ZERO_STRAT;
				end else if (free_head_q >= gha_pkg::LINK_W'(gha_pkg::CAPACITY) ||
						free_head_q >= active_q) begin
					st_d = gha_pkg::ST_FULL;
				end else begin
					ex_we         = 1'b1;
					ex_meta.alloc = 1'b1;
					pay_we        = 1'b1;
					head_ld       = 1'b1;
					head_d        = rd_meta.link;
					idx_d         = gha_pkg::HIDX_W'(addr_q);
					gen_d         = gha_pkg::HGEN_W'(rd_meta.gen);
				end
			end
			gha_pkg::CMD_LOOKUP, gha_pkg::CMD_RELEASE: begin
				if (gha_pkg::LINK_W'(hidx_q) >= active_q) begin
					st_d = gha_pkg::ST_RANGE;
				end else if (!rd_meta.alloc || 32'(rd_meta.gen) != 32'(hgen_q)) begin
					st_d = gha_pkg::ST_STALE;
				end else if (cmd_q == gha_pkg::CMD_LOOKUP) begin
					pay_d = rd_pay;
				end else begin
					ex_we         = 1'b1;
					ex_meta.gen   = rd_meta.gen + gha_pkg::GEN_BITS'(1);
					ex_meta.alloc = 1'b0;
					ex_meta.link  = free_head_q;
					head_ld       = 1'b1;
					head_d        = gha_pkg::LINK_W'(hidx_q);
				end
			end
			gha_pkg::CMD_GROW: begin
				if (count_q == '0 ||
						32'(count_q) > 32'(gha_pkg::CAPACITY) - 32'(active_q)) begin
					st_d = gha_pkg::ST_BAD_GROW;
				end else begin
					grow_ok = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign grow_end = active_q + gha_pkg::LINK_W'(count_q);

	// walker start: full rebuild on config, new run of slots on grow
	always_comb begin
		walk_cmd = '0;
		if (cfg_wr) begin
			walk_cmd.start     = 1'b1;
			walk_cmd.first     = '0;
			walk_cmd.stop      = gha_pkg::LINK_W'(gha_pkg::CAPACITY);
			walk_cmd.chain_end = cfg_size;
			walk_cmd.tail      = gha_pkg::LINK_NONE;
			walk_cmd.gen       = '0;
		end else if (exec_fire && grow_ok) begin
			walk_cmd.start     = 1'b1;
			walk_cmd.first     = active_q;
			walk_cmd.stop      = grow_end;
			walk_cmd.chain_end = grow_end;
			walk_cmd.tail      = free_head_q;
			walk_cmd.gen       = gha_pkg::GEN_BITS'(1);
		end
	end

	gha_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (walk_cmd),
		.st     (walk)
	);

	// walker and execute cycle never write in the same cycle
	always_comb begin
		if (walk.busy) begin
			m_we    = 1'b1;
			m_waddr = walk.addr;
			m_wdata = walk.data;
		end else begin
			m_we    = exec_fire && ex_we;
			m_waddr = addr_q;
			m_wdata = ex_meta;
		end
	end

	gha_ram #(.W(gha_pkg::META_W), .D(gha_pkg::CAPACITY)) u_meta_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (rd_addr),
		.rdata (rd_word)
	);

	// payloads are only read back from allocated slots, so no clearing
	gha_ram #(.W(gha_pkg::PAY_W), .D(gha_pkg::CAPACITY)) u_pay_ram (
		.clk   (clk),
		.we    (exec_fire && pay_we),
		.waddr (addr_q),
		.wdata (payload_q),
		.raddr (rd_addr),
		.rdata (rd_pay)
	);

	// sequencer and table registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gha_pkg::S_CLEAR;
			free_head_q <= '0;
			active_q    <= gha_pkg::LINK_W'(gha_pkg::SIZE_RESET);
		end else if (cfg_wr) begin
			state_q     <= gha_pkg::S_CLEAR;
			free_head_q <= '0;
			active_q    <= cfg_size;
		end else begin
			unique case (state_q)
				gha_pkg::S_CLEAR: begin
					if (!walk.busy) begin
						state_q <= gha_pkg::S_IDLE;
					end
				end
				gha_pkg::S_IDLE: begin
					if (req_acc) begin
						state_q <= gha_pkg::S_EXEC;
					end
				end
				gha_pkg::S_EXEC: begin
					if (out_free) begin
						if (head_ld) begin
							free_head_q <= head_d;
						end
						if (grow_ok) begin
							// new slots go ahead of the old free list
							free_head_q <= active_q;
							active_q    <= grow_end;
							state_q     <= gha_pkg::S_GROW;
						end else begin
							state_q <= gha_pkg::S_IDLE;
						end
					end
				end
				gha_pkg::S_GROW: begin
					if (!walk.busy) begin
						state_q <= gha_pkg::S_IDLE;
					end
				end
				default: state_q <= gha_pkg::S_CLEAR;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (req_acc) begin
			cmd_q     <= gha_pkg::cmd_t'(req.cmd);
			payload_q <= req.payload;
			strat_q   <= req.strategy_id;
			hidx_q    <= gha_pkg::IDX_W'(req.handle_index);
			hgen_q    <= req.handle_generation;
			count_q   <= req.grow_count;
			addr_q    <= rd_addr;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			rsp_status_q <= st_d;
			rsp_idx_q    <= idx_d;
			rsp_gen_q    <= gen_d;
			rsp_pay_q    <= pay_d;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.out_index      = rsp_idx_q;
	assign rsp.out_generation = rsp_gen_q;
	assign rsp.out_payload    = rsp_pay_q;

	// walker only runs during a clearing pass or a grow
	a_walk_state: assert property (@(posedge clk) disable iff (!arst_n)
		walk.busy |-> (state_q == gha_pkg::S_CLEAR || state_q == gha_pkg::S_GROW))
		else $error("walker busy outside clear/grow");

	// no request taken while slots are being rewritten
	a_ready_walk: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !walk.busy)
		else $error("request accepted during walk");

	// free head is a slot index or the end marker
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q <= gha_pkg::LINK_W'(gha_pkg::CAPACITY))
		else $error("free head out of range");

	// active size stays within 1..capacity
	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q != '0 && active_q <= gha_pkg::LINK_W'(gha_pkg::CAPACITY))
		else $error("active size out of range");

	// a response only appears after an execute cycle
	a_rsp_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == gha_pkg::S_EXEC))
		else $error("response without execute cycle");

endmodule
`default_nettype wire

// ===== tb/generational_handle_allocator_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the generational handle allocator: random and directed requests.
module generational_handle_allocator_test;
	import gha_pkg::*;

	typedef struct packed {
		cmd_t                 cmd;
		logic [PAY_W-1:0]     payload;
		logic [STRAT_W-1:0]   strategy_id;
		logic [HIDX_W-1:0]    handle_index;
		logic [HGEN_W-1:0]    handle_generation;
		logic [CNT_W-1:0]     grow_count;
	} handle_req_t;

	typedef struct packed {
		status_t              status;
		logic [HIDX_W-1:0]    index;
		logic [HGEN_W-1:0]    generation;
		logic [PAY_W-1:0]     payload;
	} handle_rsp_t;

	// clock and the one reset pulse; every block input is known from time 0
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// driven values, tied to the channels below
	handle_req_t drv_req = '0;
	logic req_valid = 1'b0;
	logic rsp_ready = 1'b0;
	logic cfg_valid = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;

	gha_cfg_if cfg_bus();
	gha_req_if req_bus();
	gha_rsp_if rsp_bus();

	assign cfg_bus.valid = cfg_valid;
	assign cfg_bus.data = cfg_data;
	assign req_bus.valid = req_valid;
	assign req_bus.cmd = drv_req.cmd;
	assign req_bus.payload = drv_req.payload;
	assign req_bus.strategy_id = drv_req.strategy_id;
	assign req_bus.handle_index = drv_req.handle_index;
	assign req_bus.handle_generation = drv_req.handle_generation;
	assign req_bus.grow_count = drv_req.grow_count;
	assign rsp_bus.ready = rsp_ready;

	generational_handle_allocator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.req(req_bus),
		.rsp(rsp_bus)
	);

	always #2 clk = ~clk;

	// shadow of the handle table
	logic [HGEN_W-1:0] tbl_gen [CAPACITY];
	bit                tbl_used [CAPACITY];
	logic [PAY_W-1:0]  tbl_data [CAPACITY];
	logic [LINK_W-1:0] tbl_next [CAPACITY];
	logic [LINK_W-1:0] free_top;
	int                tbl_size;

	handle_req_t req_backlog[$];   // requests waiting for the driver
	handle_rsp_t rsp_due[$];       // responses owed by the block, oldest first
	handle_rsp_t rsp_want;

	bit req_taken;                 // request handshake at the last rising edge
	bit hold_rsp = 1'b0;           // long receiver stall
	bit press_go = 1'b0;
	int req_idle_pct = 19;
	int rsp_idle_pct = 68;
	int n_taken = 0;
	int n_fail = 0;

	// fresh table: nothing allocated, free chain 0..n-1 from head 0
	function automatic void rebuild_table(int n);
		tbl_size = n;
		free_top = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			tbl_gen[i] = '0;
			tbl_used[i] = 1'b0;
			tbl_next[i] = (i + 1 < n) ? LINK_W'(i + 1) : LINK_NONE;
		end
	endfunction

	// applies one request to the shadow table and returns the response it owes
	function automatic handle_rsp_t table_response(handle_req_t r);
		handle_rsp_t o;
		int s;
		int stop;
		o = '0;
		o.status = ST_OK;
		case (r.cmd)
			CMD_ALLOC: begin
				if (r.strategy_id == '0) begin
					o.status = ST_ZERO_STRAT;
				end else if (free_top >= CAPACITY || free_top >= tbl_size) begin
					o.status = ST_FULL;
				end else begin
					s = free_top;
					free_top = tbl_next[s];
					tbl_used[s] = 1'b1;
					tbl_data[s] = r.payload;
					o.index = HIDX_W'(s);
					o.generation = tbl_gen[s];
				end
			end
			CMD_LOOKUP, CMD_RELEASE: begin
				s = r.handle_index;
				if (s >= tbl_size) begin
					o.status = ST_RANGE;
				end else if (!tbl_used[s] || tbl_gen[s] != r.handle_generation) begin
					o.status = ST_STALE;
				end else if (r.cmd == CMD_LOOKUP) begin
					o.payload = tbl_data[s];
				end else begin
					// generation wraps; slot goes back on the head of the free list
					tbl_used[s] = 1'b0;
					tbl_gen[s] = tbl_gen[s] + 1'b1;
					tbl_next[s] = free_top;
					free_top = LINK_W'(s);
				end
			end
			default: begin
				if (r.grow_count == '0 || r.grow_count > CAPACITY - tbl_size) begin
					o.status = ST_BAD_GROW;
				end else begin
					// new slots start at generation 1, chained ahead of the old free list
					stop = tbl_size + r.grow_count;
					for (int i = tbl_size; i < stop; i++) begin
						tbl_gen[i] = HGEN_W'(1);
						tbl_used[i] = 1'b0;
						tbl_next[i] = (i + 1 < stop) ? LINK_W'(i + 1) : free_top;
					end
					free_top = LINK_W'(tbl_size);
					tbl_size = stop;
				end
			end
		endcase
		return o;
	endfunction

	// some allocated slot, searched from a random start
	function automatic bit find_live(output logic [HIDX_W-1:0] li, output logic [HGEN_W-1:0] lg);
		int start;
		int j;
		li = '0;
		lg = '0;
		start = $urandom_range(tbl_size - 1);
		for (int k = 0; k < tbl_size; k++) begin
			j = (start + k) % tbl_size;
			if (tbl_used[j]) begin
				li = HIDX_W'(j);
				lg = tbl_gen[j];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// mostly well-formed traffic: live handles, small valid grows, nonzero owners
	function automatic handle_req_t random_request();
		handle_req_t r;
		int roll;
		int spare;
		logic [HIDX_W-1:0] li;
		logic [HGEN_W-1:0] lg;
		r.cmd = cmd_t'($urandom_range(3));
		r.payload = {$urandom, $urandom};
		r.strategy_id = STRAT_W'($urandom);
		r.handle_index = HIDX_W'($urandom);
		r.handle_generation = HGEN_W'($urandom);
		r.grow_count = CNT_W'($urandom);
		roll = $urandom_range(99);
		spare = CAPACITY - tbl_size;
		if (roll < 35) begin
			r.cmd = CMD_ALLOC;
			r.strategy_id = ($urandom_range(19) == 0) ? '0 : STRAT_W'($urandom_range(255, 1));
		end else if (roll < 85) begin
			r.cmd = (roll < 60) ? CMD_LOOKUP : CMD_RELEASE;
			if ($urandom_range(9) < 8 && find_live(li, lg)) begin
				r.handle_index = li;
				r.handle_generation = lg;
			end
		end else if (roll < 93) begin
			r.cmd = CMD_GROW;
			if (spare > 0) begin
				r.grow_count = ($urandom_range(7) == 0) ? CNT_W'(spare) :
					CNT_W'($urandom_range((spare < 12) ? spare : 12, 1));
			end
		end
		// else: fully random noise
		return r;
	endfunction

	function automatic void note_failure(string what);
		n_fail++;
		if (n_fail <= 10)
			$display("%0t ns: %s", $time, what);
	endfunction

	// sender: new request only once the previous one was taken; idles at random
	always @(negedge clk) begin
		if (!req_valid || req_taken) begin
			if (req_backlog.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
				drv_req = req_backlog.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus the long hold-off
	always @(negedge clk)
		rsp_ready <= !hold_rsp && ($urandom_range(99) >= rsp_idle_pct);

	// monitor: config and request handshakes update the shadow table, responses are checked
	always @(posedge clk) begin
		req_taken = arst_n && req_valid && req_bus.ready;
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++)
				tbl_data[i] = '0;
			rebuild_table(SIZE_RESET);
		end else begin
			// a zero size is ignored, oversize saturates
			if (cfg_valid && cfg_bus.ready && cfg_data != '0)
				rebuild_table((cfg_data > CAPACITY) ? CAPACITY : int'(cfg_data));
			if (req_taken) begin
				rsp_due.push_back(table_response(drv_req));
				n_taken++;
			end
			if (rsp_bus.valid && rsp_ready) begin
				if (rsp_due.size() == 0) begin
					note_failure($sformatf("unexpected response, status %0d", rsp_bus.status));
				end else begin
					rsp_want = rsp_due.pop_front();
					if (rsp_bus.status !== rsp_want.status ||
							rsp_bus.out_index !== rsp_want.index ||
							rsp_bus.out_generation !== rsp_want.generation ||
							rsp_bus.out_payload !== rsp_want.payload)
						note_failure($sformatf({"mismatch: expected st %0d idx %0d gen %0d pay %h,",
							" got st %0d idx %0d gen %0d pay %h"},
							rsp_want.status, rsp_want.index, rsp_want.generation,
							rsp_want.payload, rsp_bus.status, rsp_bus.out_index,
							rsp_bus.out_generation, rsp_bus.out_payload));
				end
			end
		end
	end

	// long receiver stall while requests keep coming: the block must back up
	initial begin
		wait (press_go);
		@(posedge clk);
		hold_rsp = 1'b1;
		repeat (300) @(posedge clk);
		hold_rsp = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic queue_req(cmd_t c, logic [PAY_W-1:0] pay, logic [STRAT_W-1:0] owner,
			logic [HIDX_W-1:0] hi, logic [HGEN_W-1:0] hg, logic [CNT_W-1:0] cnt);
		handle_req_t r;
		r.cmd = c;
		r.payload = pay;
		r.strategy_id = owner;
		r.handle_index = hi;
		r.handle_generation = hg;
		r.grow_count = cnt;
		req_backlog.push_back(r);
	endtask

	// all requests taken and every response back
	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (req_backlog.size() != 0 || req_valid || rsp_due.size() != 0);
	endtask

	// size write only when idle; a grow walk may still run past its response
	task automatic set_size(logic [CFG_W-1:0] v);
		wait_drained();
		repeat (1100) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		#1;
	endtask

	initial begin
		int phase_size [6];
		phase_size = '{2047, 1, 24, 1024, 5, 300};
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// reset size 1024: owner check, lookups, release, stale and free handles, grow rejects
		queue_req(CMD_ALLOC, 64'h1234_5678_9ABC_DEF0, 8'h00, '0, '0, '0);
		queue_req(CMD_ALLOC, '1, 8'hFF, '0, '0, '0);
		queue_req(CMD_ALLOC, '0, 8'h01, '0, '0, '0);
		queue_req(CMD_LOOKUP, '0, '0, 10'd0, 16'd0, '0);
		queue_req(CMD_LOOKUP, '0, '0, 10'd0, 16'hFFFF, '0);
		queue_req(CMD_LOOKUP, '0, '0, 10'd1023, 16'd0, '0);
		queue_req(CMD_RELEASE, '0, '0, 10'd0, 16'd0, '0);
		queue_req(CMD_RELEASE, '0, '0, 10'd0, 16'd0, '0);
		queue_req(CMD_LOOKUP, '0, '0, 10'd0, 16'd1, '0);
		queue_req(CMD_ALLOC, 64'hA5A5_5A5A_0F0F_F0F0, 8'h80, '0, '0, '0);
		queue_req(CMD_GROW, '0, '0, '0, '0, 11'd0);
		queue_req(CMD_GROW, '0, '0, '0, '0, 11'd1);
		queue_req(CMD_GROW, '0, '0, '0, '0, 11'h7FF);

		// two slots: full table, out-of-range handles, grow to capacity
		set_size(11'd2);
		queue_req(CMD_ALLOC, 64'd1, 8'h01, '0, '0, '0);
		queue_req(CMD_ALLOC, 64'd2, 8'h02, '0, '0, '0);
		queue_req(CMD_ALLOC, 64'd3, 8'h03, '0, '0, '0);
		queue_req(CMD_LOOKUP, '0, '0, 10'd2, 16'd0, '0);
		queue_req(CMD_RELEASE, '0, '0, 10'd1023, 16'hFFFF, '0);
		queue_req(CMD_GROW, '0, '0, '0, '0, 11'd1023);
		queue_req(CMD_GROW, '0, '0, '0, '0, 11'd1022);
		queue_req(CMD_ALLOC, 64'hDEAD_BEEF_0000_0001, 8'h7F, '0, '0, '0);
		queue_req(CMD_LOOKUP, '0, '0, 10'd2, 16'd1, '0);
		queue_req(CMD_RELEASE, '0, '0, 10'd2, 16'd1, '0);
		queue_req(CMD_GROW, '0, '0, '0, '0, 11'd1);

		// zero size write must leave the table alone: slot 0 still live
		set_size(11'd0);
		queue_req(CMD_LOOKUP, '0, '0, 10'd0, 16'd0, '0);

		// random phases; first oversize (saturates), then small and full sizes
		for (int p = 0; p < 6; p++) begin
			set_size(CFG_W'(phase_size[p]));
			if (p < 2) begin
				req_idle_pct = 19;
				rsp_idle_pct = 68;
			end else if (p < 4) begin
				req_idle_pct = 68;
				rsp_idle_pct = 19;
			end else begin
				req_idle_pct = 0;
				rsp_idle_pct = 0;
			end
			if (p == 4)
				press_go = 1'b1;
			repeat (285) begin
				// keep the backlog short so live handles come from a current table
				while (req_backlog.size() >= 2) begin
					@(posedge clk);
					#1;
				end
				req_backlog.push_back(random_request());
			end
		end

		wait_drained();
		repeat (64) @(posedge clk);
		if (n_fail == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
